/* design/sst_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set toggle package
// Beat types, result codes and the status that cells share with neighbors.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned CatW     = 2;
  localparam int unsigned ItemW    = 8;
  localparam int unsigned OutcomeW = 2;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CountW   = 5;

  typedef enum logic [OutcomeW-1:0] {
    OUT_INSERTED = 2'd0,
    OUT_REMOVED  = 2'd1,
    OUT_REJECTED = 2'd2
  } sst_outcome_e;

  typedef struct packed {
    logic [CatW-1:0]  category;
    logic [ItemW-1:0] item_id;
  } sst_in_t;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [SlotW-1:0]    slot;
    logic [CountW-1:0]   new_count;
  } sst_out_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } sst_cmd_t;

  // What a cell reports about its entry of the selected list.
  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
    logic gt;
  } sst_stat_t;

endpackage

/* design/sst_cell.sv */
// ----------------------------------------------------------------------------
// Sorted set toggle cell
// Holds one slot of every list, compares it with the identifier and takes
// its neighbor's entry when the list shifts.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned NUM_LISTS = 3,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned LIST_W    = 2,
  parameter int unsigned K         = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sst_pkg::sst_cmd_t   cmd_i,
  input  logic [LIST_W-1:0]   list_i,
  input  logic [ID_BITS-1:0]  id_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [ID_BITS-1:0]  prv_entry_i,
  input  sst_pkg::sst_stat_t  prv_stat_i,
  input  logic [ID_BITS-1:0]  nxt_entry_i,
  input  sst_pkg::sst_stat_t  nxt_stat_i,
  output logic [ID_BITS-1:0]  entry_o,
  output sst_pkg::sst_stat_t  stat_o
);
  import sst_pkg::*;

  logic [ID_BITS-1:0] entry_q [NUM_LISTS];
  logic [ID_BITS-1:0] entry_d;
  logic               valid, at_top, wr;

  assign entry_o = entry_q[list_i];
  assign valid   = CNT_W'(K) < count_i;
  assign at_top  = CNT_W'(K) == count_i;

  assign stat_o.valid = valid;
  assign stat_o.lt    = valid && (entry_o < id_i);
  assign stat_o.eq    = valid && (entry_o == id_i);
  assign stat_o.gt    = valid && (entry_o > id_i);

  // A removal pulls every entry at or above the identifier down one slot;
  // an insertion pushes every larger entry up and drops the identifier into
  // the lowest slot that opened.
  always_comb begin
    entry_d = entry_o;
    wr      = 1'b0;
    if (cmd_i.rem && valid && !stat_o.lt) begin
      wr      = 1'b1;
      entry_d = nxt_stat_i.valid ? nxt_entry_i : '0;
    end else if (cmd_i.ins && (stat_o.gt || at_top)) begin
      wr      = 1'b1;
      entry_d = prv_stat_i.gt ? prv_entry_i : id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        entry_q[i] <= '0;
      end
    end else if (wr) begin
      entry_q[list_i] <= entry_d;
    end
  end

endmodule

/* design/sorted_set_toggle.sv */
// ----------------------------------------------------------------------------
// Sorted set toggle
// Keeps one ascending list of identifiers per category and toggles an
// identifier's membership on every beat that is not rejected.
// ----------------------------------------------------------------------------
// A beat names a category and an identifier. If the identifier is in that
// list it is removed, otherwise it is inserted at its sorted place; an insert
// into a full list, or a category past the last list, is rejected and changes
// nothing. The beat is taken into the input register; while it sits there,
// every slot of the row of cells compares and shifts in parallel, and the
// output register then captures the result. With the output side not
// stalling, a new beat is taken every cycle. Reset clears all lists at
// once; no clearing pass follows it.
module sorted_set_toggle #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned NUM_LISTS = 3,
  parameter int unsigned ID_BITS   = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sst_pkg::sst_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sst_pkg::sst_out_t out_data_o
);
  import sst_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W  = $clog2(CAPACITY);
  localparam int unsigned LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  // Input register.
  logic             in_vld_q, in_vld_d;
  sst_in_t          in_q;
  logic             accept, fire;

  // Output register.
  logic             out_vld_q, out_vld_d;
  sst_out_t         out_q, out_d;

  logic [CNT_W-1:0] count_q [NUM_LISTS];
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] count;
  logic [LIST_W-1:0] list_idx;
  logic [ID_BITS-1:0] id;
  logic             cat_ok, found, full;
  sst_cmd_t         cmd;

  logic [ID_BITS-1:0] ent [CAPACITY];
  sst_stat_t          stat [CAPACITY];
  logic [CAPACITY-1:0] eq_vec, bnd_vec;
  logic [POS_W-1:0]    pos;

  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  assign cat_ok   = 32'(in_q.category) < NUM_LISTS;
  assign list_idx = LIST_W'(in_q.category);
  assign id       = ID_BITS'(in_q.item_id);
  assign count    = count_q[list_idx];

  // Row of cells; each one sees its neighbors' entries and status.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ID_BITS-1:0] prv_ent, nxt_ent;
    sst_stat_t          prv_st, nxt_st;

    if (k == 0) begin : g_first
      assign prv_ent = '0;
      assign prv_st  = '0;
    end else begin : g_mid_lo
      assign prv_ent = ent[k-1];
      assign prv_st  = stat[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign nxt_ent = '0;
      assign nxt_st  = '0;
    end else begin : g_mid_hi
      assign nxt_ent = ent[k+1];
      assign nxt_st  = stat[k+1];
    end

    sst_cell #(
      .ID_BITS  (ID_BITS),
      .NUM_LISTS(NUM_LISTS),
      .CNT_W    (CNT_W),
      .LIST_W   (LIST_W),
      .K        (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .list_i     (list_idx),
      .id_i       (id),
      .count_i    (count),
      .prv_entry_i(prv_ent),
      .prv_stat_i (prv_st),
      .nxt_entry_i(nxt_ent),
      .nxt_stat_i (nxt_st),
      .entry_o    (ent[k]),
      .stat_o     (stat[k])
    );

    // The smaller entries form a prefix, so its upper edge marks at most one slot.
    assign eq_vec[k]  = stat[k].eq;
    assign bnd_vec[k] = ((k == 0) || prv_st.lt) && !stat[k].lt;
  end

  assign found = |eq_vec;
  assign full  = count == CNT_W'(CAPACITY);

  always_comb begin
    pos = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (bnd_vec[k]) begin
        pos = pos | POS_W'(k);
      end
    end
  end

  always_comb begin
    cmd     = '0;
    count_d = count;
    out_d   = '0;
    out_d.outcome = OUT_REJECTED;
    if (cat_ok) begin
      out_d.new_count = CountW'(count);
      if (found) begin
        cmd.rem         = fire;
        count_d         = count - 1'b1;
        out_d.outcome   = OUT_REMOVED;
        out_d.slot      = SlotW'(pos);
        out_d.new_count = CountW'(count_d);
      end else if (!full) begin
        cmd.ins         = fire;
        count_d         = count + 1'b1;
        out_d.outcome   = OUT_INSERTED;
        out_d.slot      = SlotW'(pos);
        out_d.new_count = CountW'(count_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        count_q[i] <= '0;
      end
    end else if (cmd.ins || cmd.rem) begin
      count_q[list_idx] <= count_d;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* design/sst_checker.sv */
// ----------------------------------------------------------------------------
// Sorted set toggle checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sst_pkg::sst_out_t out_data_o
);
  import sst_pkg::*;

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.outcome == OUT_INSERTED ||
                    out_data_o.outcome == OUT_REMOVED ||
                    out_data_o.outcome == OUT_REJECTED)
    else $error("result beat carries an unknown outcome");

  // An inserted identifier lands inside the grown list.
  a_insert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_INSERTED && CAPACITY <= 16 |->
      32'(out_data_o.slot) < 32'(out_data_o.new_count))
    else $error("insert slot outside the list");

  // A removed slot was inside the list before it shrank.
  a_remove_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_REMOVED && CAPACITY <= 16 |->
      32'(out_data_o.slot) <= 32'(out_data_o.new_count))
    else $error("remove slot outside the list");

  // The block never holds off input while it has nothing to deliver.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

endmodule

bind sorted_set_toggle sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);
